FILE: sv/mwo_pkg.sv
package mwo_pkg;

   localparam int WHEEL_COUNT = 4;

   localparam int FID_W     = 11;
   localparam int POS_W     = 32;
   localparam int TIME_W    = 16;
   localparam int GAIN_W    = 24;
   localparam int ID_W      = 7;
   localparam int RATE_W    = 32;
   localparam int FRAC_BITS = 16;

   // four 32-bit deltas summed need two more bits
   localparam int SUM_W  = POS_W + 2;
   localparam int PROD_W = SUM_W + GAIN_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [3:0] REPORT_NIBBLE = 4'hB;

   localparam int WHEEL_LF = 0;
   localparam int WHEEL_LB = 1;
   localparam int WHEEL_RF = 2;
   localparam int WHEEL_RB = 3;

   localparam logic signed [GAIN_W-1:0] GAIN_RESET  = 24'sd65536;
   localparam logic [TIME_W-1:0]        STALE_RESET = 16'd200;
   localparam logic [WHEEL_COUNT-1:0][ID_W-1:0] ID_RESET = {7'd64, 7'd48, 7'd32, 7'd16};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_TRANSLATE = 3'd0,
      CSR_GAIN_ROTATE    = 3'd1,
      CSR_STALE_LIMIT    = 3'd2,
      CSR_ID_LEFT_FRONT  = 3'd3,
      CSR_ID_LEFT_BACK   = 3'd4,
      CSR_ID_RIGHT_FRONT = 3'd5,
      CSR_ID_RIGHT_BACK  = 3'd6
   } csr_index_type;

   typedef enum logic {
      FUNC_REPORT = 1'b0,
      FUNC_TICK   = 1'b1
   } func_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0]           gain_translate;
      logic signed [GAIN_W-1:0]           gain_rotate;
      logic [TIME_W-1:0]                  stale_limit;
      logic [WHEEL_COUNT-1:0][ID_W-1:0]   wheel_id;
   } cfg_type;

   typedef struct packed {
      logic load_mul;
      logic load_out;
   } lane_ctl_type;

endpackage

FILE: sv/mwo_csr.sv
module mwo_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [mwo_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mwo_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output mwo_pkg::cfg_type                   cfg
);
   import mwo_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GAIN_TRANSLATE: cfg_in.gain_translate = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_ROTATE:    cfg_in.gain_rotate    = csr_wdata[GAIN_W-1:0];
            CSR_STALE_LIMIT:    cfg_in.stale_limit    = csr_wdata[TIME_W-1:0];
            CSR_ID_LEFT_FRONT:  cfg_in.wheel_id[WHEEL_LF] = csr_wdata[ID_W-1:0];
            CSR_ID_LEFT_BACK:   cfg_in.wheel_id[WHEEL_LB] = csr_wdata[ID_W-1:0];
            CSR_ID_RIGHT_FRONT: cfg_in.wheel_id[WHEEL_RF] = csr_wdata[ID_W-1:0];
            CSR_ID_RIGHT_BACK:  cfg_in.wheel_id[WHEEL_RB] = csr_wdata[ID_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_translate <= GAIN_RESET;
         cfg_ff.gain_rotate    <= GAIN_RESET;
         cfg_ff.stale_limit    <= STALE_RESET;
         cfg_ff.wheel_id       <= ID_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/mwo_wheel_state.sv
module mwo_wheel_state (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 fire,
   input  logic                                 func,
   input  logic [mwo_pkg::FID_W-1:0]            frame_id,
   input  logic [mwo_pkg::POS_W-1:0]            wheel_position,
   input  logic [mwo_pkg::TIME_W-1:0]           now_time,
   input  mwo_pkg::cfg_type                     cfg,
   output logic                                 fresh,
   output logic signed [mwo_pkg::SUM_W-1:0]     sum_x,
   output logic signed [mwo_pkg::SUM_W-1:0]     sum_y,
   output logic signed [mwo_pkg::SUM_W-1:0]     sum_rot
);
   import mwo_pkg::*;

   logic [POS_W-1:0]  last_pos_ff [WHEEL_COUNT];
   logic [POS_W-1:0]  delta_ff    [WHEEL_COUNT];
   logic [TIME_W-1:0] rtime_ff    [WHEEL_COUNT];

   logic [WHEEL_COUNT-1:0] hit;
   logic [WHEEL_COUNT-1:0] sel;
   logic [WHEEL_COUNT-1:0] stale;
   logic                   report_ok;
   logic                   taken;
   logic [TIME_W-1:0]      age [WHEEL_COUNT];
   logic signed [SUM_W-1:0] d [WHEEL_COUNT];

   assign report_ok = fire && (func == FUNC_REPORT) && (frame_id[3:0] == REPORT_NIBBLE);

   // an id register with nonzero low nibble can never match bits 7..4
   always_comb begin
      taken = 1'b0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         hit[i] = ({frame_id[7:4], 4'b0000} == {1'b0, cfg.wheel_id[i]});
         sel[i] = hit[i] && !taken;
         taken  = taken || hit[i];
      end
   end

   always_comb begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
         age[i]   = now_time - rtime_ff[i];
         stale[i] = (age[i] > cfg.stale_limit);
         d[i]     = {{(SUM_W-POS_W){delta_ff[i][POS_W-1]}}, delta_ff[i]};
      end
   end

   assign fresh = ~|stale;

   assign sum_x   = d[WHEEL_LF] - d[WHEEL_LB] - d[WHEEL_RF] + d[WHEEL_RB];
   assign sum_y   = d[WHEEL_LF] + d[WHEEL_LB] + d[WHEEL_RF] + d[WHEEL_RB];
   assign sum_rot = d[WHEEL_RF] + d[WHEEL_RB] - d[WHEEL_LF] - d[WHEEL_LB];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            last_pos_ff[i] <= '0;
            delta_ff[i]    <= '0;
            rtime_ff[i]    <= '0;
         end
      end else begin
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            if (report_ok && sel[i]) begin
               delta_ff[i]    <= wheel_position - last_pos_ff[i];
               last_pos_ff[i] <= wheel_position;
               rtime_ff[i]    <= now_time;
            end
         end
      end
   end

endmodule

FILE: sv/mwo_rate_lane.sv
module mwo_rate_lane (
   input  logic                                 clock,
   input  mwo_pkg::lane_ctl_type                ctl,
   input  logic signed [mwo_pkg::SUM_W-1:0]     sum,
   input  logic signed [mwo_pkg::GAIN_W-1:0]    gain,
   output logic signed [mwo_pkg::RATE_W-1:0]    rate
);
   import mwo_pkg::*;

   localparam int Q_W = PROD_W - FRAC_BITS;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [Q_W-1:0]    q;
   logic signed [RATE_W-1:0] rate_ff;
   logic signed [RATE_W-1:0] rate_in;

   assign prod_in = {{GAIN_W{sum[SUM_W-1]}}, sum} * {{SUM_W{gain[GAIN_W-1]}}, gain};

   // dropping the fraction bits floors toward minus infinity
   assign q = prod_ff[PROD_W-1:FRAC_BITS];

   always_comb begin
      if (&q[Q_W-1:RATE_W-1] || ~|q[Q_W-1:RATE_W-1]) begin
         rate_in = q[RATE_W-1:0];
      end else if (q[Q_W-1]) begin
         rate_in = {1'b1, {(RATE_W-1){1'b0}}};
      end else begin
         rate_in = {1'b0, {(RATE_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_mul) begin
         prod_ff <= prod_in;
      end
      if (ctl.load_out) begin
         rate_ff <= rate_in;
      end
   end

   assign rate = rate_ff;

endmodule

FILE: sv/mecanum_wheel_odometry.sv
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    func, frame_id, wheel_position, now_time
// rsp       out        rsp_valid/stall    rate_x, rate_y, rate_rot
// csr       in         csr_wr_en          csr_index, csr_wdata
//
// One beat per cycle is accepted while req_stall is low; a tick result reaches rsp through
// the input register, sum/age stage, multiplier register and output register, in that order.
// Reports update wheel state as they leave the input register and give no result.
// Reset is synchronous: wheel state clears to zero, registers take their defaults.
// rsp_stall backs up stage by stage; req_stall rises only when every stage holds a beat.
module mecanum_wheel_odometry (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic [mwo_pkg::FID_W-1:0]            req_frame_id,
   input  logic [mwo_pkg::POS_W-1:0]            req_wheel_position,
   input  logic [mwo_pkg::TIME_W-1:0]           req_now_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [mwo_pkg::RATE_W-1:0]    rsp_rate_x,
   output logic signed [mwo_pkg::RATE_W-1:0]    rsp_rate_y,
   output logic signed [mwo_pkg::RATE_W-1:0]    rsp_rate_rot,
   input  logic                                 csr_wr_en,
   input  logic [mwo_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mwo_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import mwo_pkg::*;

   cfg_type      cfg;
   lane_ctl_type lane_ctl;

   logic v0_ff, v0_in;
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic rdy0, rdy1, rdy2, rdy_out;
   logic s0_fire;

   logic              func_ff;
   logic [FID_W-1:0]  frame_id_ff;
   logic [POS_W-1:0]  position_ff;
   logic [TIME_W-1:0] now_ff;

   logic                    fresh;
   logic signed [SUM_W-1:0] sum_x, sum_y, sum_rot;
   logic signed [SUM_W-1:0] sum_x_ff, sum_y_ff, sum_rot_ff;

   // each stage advances when empty or when the one after it moves
   assign rdy_out = !rsp_valid_ff || !rsp_stall;
   assign rdy2    = !v2_ff || rdy_out;
   assign rdy1    = !v1_ff || rdy2;
   assign rdy0    = !v0_ff || rdy1;
   assign s0_fire = v0_ff && rdy1;

   assign req_stall = !rdy0;

   assign v0_in        = rdy0    ? req_valid : v0_ff;
   assign v1_in        = rdy1    ? (v0_ff && (func_ff == FUNC_TICK) && fresh) : v1_ff;
   assign v2_in        = rdy2    ? v1_ff : v2_ff;
   assign rsp_valid_in = rdy_out ? v2_ff : rsp_valid_ff;

   assign lane_ctl.load_mul = rdy2;
   assign lane_ctl.load_out = rdy_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v0_ff        <= v0_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0) begin
         func_ff     <= req_func;
         frame_id_ff <= req_frame_id;
         position_ff <= req_wheel_position;
         now_ff      <= req_now_time;
      end
      if (rdy1) begin
         sum_x_ff   <= sum_x;
         sum_y_ff   <= sum_y;
         sum_rot_ff <= sum_rot;
      end
   end

   mwo_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mwo_wheel_state u_state (
      .clock          (clock),
      .reset          (reset),
      .fire           (s0_fire),
      .func           (func_ff),
      .frame_id       (frame_id_ff),
      .wheel_position (position_ff),
      .now_time       (now_ff),
      .cfg            (cfg),
      .fresh          (fresh),
      .sum_x          (sum_x),
      .sum_y          (sum_y),
      .sum_rot        (sum_rot)
   );

   mwo_rate_lane u_lane_x (
      .clock (clock),
      .ctl   (lane_ctl),
      .sum   (sum_x_ff),
      .gain  (cfg.gain_translate),
      .rate  (rsp_rate_x)
   );

   mwo_rate_lane u_lane_y (
      .clock (clock),
      .ctl   (lane_ctl),
      .sum   (sum_y_ff),
      .gain  (cfg.gain_translate),
      .rate  (rsp_rate_y)
   );

   mwo_rate_lane u_lane_rot (
      .clock (clock),
      .ctl   (lane_ctl),
      .sum   (sum_rot_ff),
      .gain  (cfg.gain_rotate),
      .rate  (rsp_rate_rot)
   );

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_report_no_result: assert property (@(posedge clock) disable iff (reset)
      (s0_fire && (func_ff == FUNC_REPORT)) |=> !v1_ff)
      else $error("report beat entered the rate pipeline");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v0_ff && v1_ff && v2_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with a free pipeline slot");

   a_result_from_stage2: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(v2_ff))
      else $error("result appeared without a multiplier stage beat");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !rdy2) |=> v2_ff)
      else $error("stage two beat lost under stall");
`endif

endmodule
